// ===== rtl/mchw_pkg.sv =====
// Shared types and constants for the heartbeat watchdog table.
`timescale 1ns / 1ps
`default_nettype none

package mchw_pkg;

    localparam int FUNC_W      = 3;
    localparam int PID_W       = 22;
    localparam int CONN_W      = 8;
    localparam int CNT_W       = 8;
    localparam int ACT_W       = 3;
    localparam int TDATA_W     = 32;
    localparam int DEF_ENTRIES = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] MAX_PINGS_RESET = CNT_W'(3);
    localparam logic [CNT_W-1:0] MISS_SAT        = {CNT_W{1'b1}};

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_REGISTER = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_PONG     = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_TICK     = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FUNC_EXPIRE   = FUNC_W'(4);
    localparam logic [FUNC_W-1:0] FUNC_CLOSE    = FUNC_W'(5);

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 3'd0,
        ACT_PING  = 3'd1,
        ACT_ABORT = 3'd2,
        ACT_KILL  = 3'd3,
        ACT_FULL  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        OP_REG,
        OP_PONG,
        OP_DEL,
        OP_TICK,
        OP_EXPIRE,
        OP_CLOSE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_WALK,
        BS_FINISH
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [PID_W-1:0]  pid;
        logic [CONN_W-1:0] conn;
    } cmd_t;

    typedef struct packed {
        logic              abort;
        logic [CNT_W-1:0]  miss;
        logic [CONN_W-1:0] conn;
        logic [PID_W-1:0]  pid;
    } slot_t;

    typedef struct packed {
        action_t           action;
        logic [PID_W-1:0]  pid;
        logic [CONN_W-1:0] conn;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/mchw_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mchw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mchw_front.sv =====
// Front end: accepts requests, decodes the function and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module mchw_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mchw_pkg::FUNC_W-1:0]   s_func,
    input  wire logic [mchw_pkg::PID_W-1:0]    s_pid,
    input  wire logic [mchw_pkg::CONN_W-1:0]   s_conn,
    output logic                               cmd_valid,
    output mchw_pkg::cmd_t                     cmd,
    input  wire logic                          cmd_pop
);

    localparam int QD     = mchw_pkg::QUEUE_DEPTH;
    localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCNT_W = $clog2(QD + 1);
    localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QD - 1);

    mchw_pkg::cmd_t    q_reg [QD];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    mchw_pkg::op_t     op;
    logic              push;

    // Classify the function code; unused codes become a no-op
    always_comb
    begin
        unique case (s_func)
            mchw_pkg::FUNC_REGISTER: op = mchw_pkg::OP_REG;
            mchw_pkg::FUNC_PONG:     op = mchw_pkg::OP_PONG;
            mchw_pkg::FUNC_DELETE:   op = mchw_pkg::OP_DEL;
            mchw_pkg::FUNC_TICK:     op = mchw_pkg::OP_TICK;
            mchw_pkg::FUNC_EXPIRE:   op = mchw_pkg::OP_EXPIRE;
            mchw_pkg::FUNC_CLOSE:    op = mchw_pkg::OP_CLOSE;
            default:                 op = mchw_pkg::OP_NOP;
        endcase
    end

    assign s_ready   = (count_reg != QCNT_W'(QD));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QLAST) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QLAST) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{op: op, pid: s_pid, conn: s_conn};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mchw_back.sv =====
// Back end: walks the slot table for each command and emits results.
`timescale 1ns / 1ps
`default_nettype none

module mchw_back #(
    parameter int ENTRIES = mchw_pkg::DEF_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    input  wire mchw_pkg::cmd_t                   cmd,
    output logic                                  cmd_pop,
    input  wire logic [mchw_pkg::CNT_W-1:0]       max_pings,
    input  wire logic                             m_ready,
    output logic                                  m_valid,
    output mchw_pkg::result_t                     m_res,
    output logic                                  m_last,
    output logic [mchw_pkg::RES_CNT_W-1:0]        res_cnt
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W = $bits(mchw_pkg::slot_t);
    localparam int RCW    = mchw_pkg::RES_CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [RCW-1:0]   RES_CAP  = RCW'(mchw_pkg::MAX_RESULTS);

    mchw_pkg::back_state_t state_reg, state_next;
    mchw_pkg::cmd_t        cmd_reg, cmd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic                  found_reg, found_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    mchw_pkg::result_t     pend_reg, pend_next;
    logic [RCW-1:0]        res_cnt_reg, res_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    mchw_pkg::result_t     m_res_reg, m_res_next;
    logic                  m_last_reg, m_last_next;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    mchw_pkg::slot_t       ram_wdata, rd_slot;
    logic [SLOT_W-1:0]     ram_rdata;

    // per-slot decode
    logic                  slot_v, pid_hit, conn_hit;
    logic [mchw_pkg::CNT_W-1:0] new_miss;
    logic                  act_hit, slot_wr, slot_clr;
    mchw_pkg::action_t     act_code;
    mchw_pkg::slot_t       slot_new;

    logic                  out_free, keep, stall;

    mchw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_slot  = mchw_pkg::slot_t'(ram_rdata);
    assign slot_v   = valid_reg[idx_reg];
    assign pid_hit  = slot_v && (rd_slot.pid == cmd_reg.pid);
    assign conn_hit = slot_v && (rd_slot.conn == cmd_reg.conn);
    assign new_miss = (rd_slot.miss == mchw_pkg::MISS_SAT) ? rd_slot.miss
                                                          : rd_slot.miss + 8'd1;
    assign out_free = !m_valid_reg || m_ready;

    // What the current command does to the slot now on the RAM output
    always_comb
    begin
        act_hit  = 1'b0;
        act_code = mchw_pkg::ACT_NONE;
        slot_wr  = 1'b0;
        slot_clr = 1'b0;
        slot_new = rd_slot;
        unique case (cmd_reg.op)
            mchw_pkg::OP_PONG:
            begin
                if (pid_hit)
                begin
                    slot_wr       = 1'b1;
                    slot_new.miss = '0;
                end
            end
            mchw_pkg::OP_DEL:
            begin
                if (pid_hit)
                begin
                    slot_clr = 1'b1;
                    act_hit  = rd_slot.abort;
                    act_code = mchw_pkg::ACT_KILL;
                end
            end
            mchw_pkg::OP_TICK:
            begin
                if (slot_v)
                begin
                    slot_wr       = 1'b1;
                    slot_new.miss = new_miss;
                    if (new_miss == max_pings)
                    begin
                        act_hit        = !rd_slot.abort;
                        act_code       = mchw_pkg::ACT_ABORT;
                        slot_new.abort = 1'b1;
                    end
                    else
                    begin
                        act_hit  = 1'b1;
                        act_code = mchw_pkg::ACT_PING;
                    end
                end
            end
            mchw_pkg::OP_EXPIRE:
            begin
                if (pid_hit)
                begin
                    slot_clr = 1'b1;
                    act_hit  = 1'b1;
                    act_code = mchw_pkg::ACT_KILL;
                end
            end
            mchw_pkg::OP_CLOSE:
            begin
                if (conn_hit)
                begin
                    slot_clr = 1'b1;
                    act_hit  = 1'b1;
                    act_code = mchw_pkg::ACT_KILL;
                end
            end
            default:
            begin
            end
        endcase
    end

    // results beyond the cap are dropped; state updates still happen
    assign keep  = act_hit && (res_cnt_reg < RES_CAP);
    assign stall = (state_reg == mchw_pkg::BS_WALK) && keep && pend_valid_reg && !out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mchw_pkg::BS_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = mchw_pkg::BS_WALK;
                end
            end
            mchw_pkg::BS_WALK:
            begin
                if (!stall && idx_reg == LAST_IDX)
                begin
                    state_next = mchw_pkg::BS_FINISH;
                end
            end
            mchw_pkg::BS_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mchw_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = mchw_pkg::BS_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_cnt_next    = res_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        cmd_pop         = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg + IDX_W'(1);
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = slot_new;

        unique case (state_reg)
            mchw_pkg::BS_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd;
                    idx_next        = '0;
                    ram_re          = 1'b1;
                    ram_raddr       = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    res_cnt_next    = '0;
                end
            end
            mchw_pkg::BS_WALK:
            begin
                if (!stall)
                begin
                    if (keep)
                    begin
                        if (pend_valid_reg)
                        begin
                            m_valid_next = 1'b1;
                            m_res_next   = pend_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = '{action: act_code, pid: rd_slot.pid,
                                            conn: rd_slot.conn};
                        res_cnt_next    = res_cnt_reg + RCW'(1);
                    end
                    ram_we = slot_wr;
                    if (slot_clr)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (cmd_reg.op == mchw_pkg::OP_REG)
                    begin
                        if (pid_hit)
                        begin
                            found_next = 1'b1;
                        end
                        if (!slot_v && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    if (idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        ram_re   = 1'b1;
                    end
                end
            end
            mchw_pkg::BS_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        m_res_next = pend_reg;
                    end
                    else if (cmd_reg.op == mchw_pkg::OP_REG && !found_reg && !free_found_reg)
                    begin
                        m_res_next = '{action: mchw_pkg::ACT_FULL, pid: cmd_reg.pid,
                                       conn: cmd_reg.conn};
                    end
                    else
                    begin
                        m_res_next = '{action: mchw_pkg::ACT_NONE, pid: '0, conn: '0};
                    end
                    if (cmd_reg.op == mchw_pkg::OP_REG && !found_reg && free_found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = free_idx_reg;
                        ram_wdata = '{abort: 1'b0, miss: '0, conn: cmd_reg.conn,
                                      pid: cmd_reg.pid};
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mchw_pkg::BS_IDLE;
            valid_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            res_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            pend_valid_reg  <= pend_valid_next;
            res_cnt_reg     <= res_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pend_reg       <= pend_next;
        m_res_reg      <= m_res_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;
    assign res_cnt = res_cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/multi_client_heartbeat_watchdog.sv =====
// Top level of the heartbeat watchdog table: ports, config register, front and back.
`timescale 1ns / 1ps
`default_nettype none

// Heartbeat watchdog table for up to ENTRIES watched clients. Each request
// carries a function (register, pong, delete, tick, grace expiry, connection
// closed) in s_axis_tuser and a process id and connection id in s_axis_tdata.
// The front end decodes requests into a two-deep command queue, so up to two
// requests are taken while the back end is busy. The back end walks every
// slot of the table once per command, one slot a cycle unless the result
// side stalls, through the single read port of the slot RAM. Results of one
// request come out in slot order; the last one carries m_axis_tlast, and a
// request with no action gives a single "none" result. At most sixteen
// results are delivered per request; further actions are dropped but their
// table updates still happen. max_pings is written through cfg_we/cfg_wdata
// and resets to 3; write it only while no request is in flight. The valid
// bits reset at once, so there is no clearing pass after reset.
module multi_client_heartbeat_watchdog #(
    parameter int ENTRIES = mchw_pkg::DEF_ENTRIES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request side
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [21:0] proc_id, [29:22] conn_id, [31:30] zero
    input  wire logic [mchw_pkg::TDATA_W-1:0]    s_axis_tdata,
    // [2:0] func
    input  wire logic [mchw_pkg::FUNC_W-1:0]     s_axis_tuser,
    // result side
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [21:0] out_proc_id, [29:22] out_conn_id, [31:30] zero
    output logic [mchw_pkg::TDATA_W-1:0]         m_axis_tdata,
    // [2:0] action
    output logic [mchw_pkg::ACT_W-1:0]           m_axis_tuser,
    output logic                                 m_axis_tlast,
    // configuration: max_pings
    input  wire logic                            cfg_we,
    input  wire logic [mchw_pkg::CNT_W-1:0]      cfg_wdata
);

    localparam int PID_W  = mchw_pkg::PID_W;
    localparam int CONN_W = mchw_pkg::CONN_W;
    localparam int PAD_W  = mchw_pkg::TDATA_W - PID_W - CONN_W;

    logic [mchw_pkg::CNT_W-1:0]     max_pings_reg, max_pings_next;
    logic                           cmd_valid;
    mchw_pkg::cmd_t                 cmd;
    logic                           cmd_pop;
    logic                           res_valid;
    mchw_pkg::result_t              res;
    logic                           res_last;
    logic [mchw_pkg::RES_CNT_W-1:0] res_cnt;

    // max_pings register
    assign max_pings_next = cfg_we ? cfg_wdata : max_pings_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pings_reg <= mchw_pkg::MAX_PINGS_RESET;
        end
        else
        begin
            max_pings_reg <= max_pings_next;
        end
    end

    mchw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_func    (s_axis_tuser),
        .s_pid     (s_axis_tdata[PID_W-1:0]),
        .s_conn    (s_axis_tdata[PID_W+CONN_W-1:PID_W]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mchw_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .max_pings (max_pings_reg),
        .m_ready   (m_axis_tready),
        .m_valid   (res_valid),
        .m_res     (res),
        .m_last    (res_last),
        .res_cnt   (res_cnt)
    );

    // result packing
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, res.conn, res.pid};
    assign m_axis_tuser  = res.action;
    assign m_axis_tlast  = res_last;

`ifndef SYNTH
    // "none" and "full" results always stand alone, so anything not last
    // must be a per-slot action
    a_mid_result_is_slot_action: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (m_axis_tuser == mchw_pkg::ACT_PING || m_axis_tuser == mchw_pkg::ACT_ABORT ||
             m_axis_tuser == mchw_pkg::ACT_KILL)
    ) else $error("non-final result with a request-level action");

    // result count never passes the per-request cap
    a_result_cap: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_cnt <= mchw_pkg::RES_CNT_W'(mchw_pkg::MAX_RESULTS)
    ) else $error("result count beyond cap");

    // a command is only popped while the queue is non-empty
    a_pop_only_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid
    ) else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire
